// ===== src/slcd_pkg.sv =====
// shared types and constants for the sync/length/checksum deframer
package slcd_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [1:0] CSR_LENGTH_LIMIT = 2'd2;

   // field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 7;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned RSP_W   = 32;

   // commands from the controller to the datapath
   typedef struct packed {
      logic sum_clear;   // timeout: drop the running sum
      logic sum_load;    // hunting: sum restarts at this byte
      logic sum_add;     // sum accumulates this byte
      logic id_load;     // capture message id
      logic len_load;    // capture length, clear fill index
      logic data_beat;   // store payload byte, advance fill index
      logic rd_clear;    // start readout at the first payload byte
      logic rd_inc;      // step readout to the next payload byte
      logic out_load;    // load the result register
   } slcd_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic sync1_match;
      logic sync2_match;
      logic len_ok;
      logic len_zero;
      logic fill_done;
      logic sum_match;
      logic rd_last;
      logic out_free;
   } slcd_sts_type;

endpackage

// ===== src/slcd_datapath.sv =====
// deframer datapath: config registers, checksum, header capture, payload memory, result register
module slcd_datapath
   import slcd_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic                clock,
   input  logic                reset,
   // configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [BYTE_W-1:0]   csr_data,
   // received byte
   input  logic [BYTE_W-1:0]   rx_byte,
   // controller interface
   input  slcd_cmd_type        cmd,
   output slcd_sts_type        sts,
   // result beat
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,
   output logic                rsp_tlast
);

   localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   logic [BYTE_W-1:0]  sync_first_ff, sync_first_in;
   logic [BYTE_W-1:0]  sync_second_ff, sync_second_in;
   logic [LEN_W-1:0]   length_limit_ff, length_limit_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  id_ff, id_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [INDEX_W-1:0] rd_idx_ff, rd_idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_id_ff;
   logic [LEN_W-1:0]   out_len_ff;
   logic [INDEX_W-1:0] out_idx_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_last_ff;
   logic [LEN_W-1:0]   limit_eff;
   logic [LEN_W-1:0]   fill_next;
   logic [LEN_W-1:0]   rd_next;
   logic               csr_write;

   logic [BYTE_W-1:0]  store_mem [MAX_PAYLOAD];
   logic [BYTE_W-1:0]  store_q_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // limit in force is the smaller of the register and the buffer depth
   assign limit_eff = (length_limit_ff > MAX_LEN) ? MAX_LEN : length_limit_ff;
   assign fill_next = fill_ff + LEN_W'(1);
   assign rd_next   = LEN_W'(rd_idx_ff) + LEN_W'(1);

   // status toward the controller
   always_comb begin
      sts.sync1_match = (rx_byte == sync_first_ff);
      sts.sync2_match = (rx_byte == sync_second_ff);
      sts.len_ok      = (rx_byte <= {1'b0, limit_eff});
      sts.len_zero    = (rx_byte == '0);
      sts.fill_done   = (fill_next >= len_ff);
      sts.sum_match   = (sum_ff == rx_byte);
      sts.rd_last     = (len_ff == '0) || (rd_next == len_ff);
      sts.out_free    = ~out_valid_ff | rsp_tready;
   end

   // next values of the control registers
   always_comb begin
      sync_first_in   = sync_first_ff;
      sync_second_in  = sync_second_ff;
      length_limit_in = length_limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SYNC_FIRST:   sync_first_in   = csr_data;
            CSR_SYNC_SECOND:  sync_second_in  = csr_data;
            CSR_LENGTH_LIMIT: length_limit_in = csr_data[LEN_W-1:0];
            default:          ;
         endcase
      end

      sum_in = sum_ff;
      if (cmd.sum_clear) begin
         sum_in = '0;
      end else if (cmd.sum_load) begin
         sum_in = rx_byte;
      end else if (cmd.sum_add) begin
         sum_in = sum_ff + rx_byte;
      end

      id_in   = cmd.id_load ? rx_byte : id_ff;
      len_in  = cmd.len_load ? rx_byte[LEN_W-1:0] : len_ff;
      fill_in = fill_ff;
      if (cmd.len_load) begin
         fill_in = '0;
      end else if (cmd.data_beat) begin
         fill_in = fill_next;
      end

      rd_idx_in = rd_idx_ff;
      if (cmd.rd_clear) begin
         rd_idx_in = '0;
      end else if (cmd.rd_inc) begin
         rd_idx_in = rd_next[INDEX_W-1:0];
      end

      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control and header registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= BYTE_W'(170);
         sync_second_ff  <= BYTE_W'(175);
         length_limit_ff <= LEN_W'(30);
         sum_ff          <= '0;
         id_ff           <= '0;
         len_ff          <= '0;
         fill_ff         <= '0;
         rd_idx_ff       <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         sync_first_ff   <= sync_first_in;
         sync_second_ff  <= sync_second_in;
         length_limit_ff <= length_limit_in;
         sum_ff          <= sum_in;
         id_ff           <= id_in;
         len_ff          <= len_in;
         fill_ff         <= fill_in;
         rd_idx_ff       <= rd_idx_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.data_beat && (fill_ff < MAX_LEN)) begin
         store_mem[fill_ff[ADDR_W-1:0]] <= rx_byte;
      end
      store_q_ff <= store_mem[rd_idx_ff[ADDR_W-1:0]];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_id_ff   <= id_ff;
         out_len_ff  <= len_ff;
         out_idx_ff  <= rd_idx_ff;
         out_byte_ff <= (len_ff == '0) ? '0 : store_q_ff;
         out_last_ff <= sts.rd_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_byte_ff, out_idx_ff, out_len_ff, out_id_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/slcd_ctrl.sv =====
// deframer controller: parse phases and payload readout sequencing
module slcd_ctrl
   import slcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         timed_out,
   input  slcd_sts_type sts,
   output slcd_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_SYNC1,
      ST_SYNC2,
      ST_ID,
      ST_LEN,
      ST_DATA,
      ST_SUM,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff != ST_READ) && (state_ff != ST_LOAD);
   assign accept     = req_tvalid & req_tready;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (accept && timed_out) begin
         cmd.sum_clear = 1'b1;
         state_in      = ST_SYNC1;
      end else begin
         case (state_ff)
            ST_SYNC1: begin
               if (accept) begin
                  cmd.sum_load = 1'b1;
                  state_in     = sts.sync1_match ? ST_SYNC2 : ST_SYNC1;
               end
            end
            ST_SYNC2: begin
               if (accept) begin
                  cmd.sum_add = 1'b1;
                  state_in    = sts.sync2_match ? ST_ID : ST_SYNC1;
               end
            end
            ST_ID: begin
               if (accept) begin
                  cmd.sum_add = 1'b1;
                  cmd.id_load = 1'b1;
                  state_in    = ST_LEN;
               end
            end
            ST_LEN: begin
               if (accept) begin
                  if (sts.len_ok) begin
                     cmd.sum_add  = 1'b1;
                     cmd.len_load = 1'b1;
                     state_in     = sts.len_zero ? ST_SUM : ST_DATA;
                  end else begin
                     state_in = ST_SYNC1;
                  end
               end
            end
            ST_DATA: begin
               if (accept) begin
                  cmd.sum_add   = 1'b1;
                  cmd.data_beat = 1'b1;
                  if (sts.fill_done) begin
                     state_in = ST_SUM;
                  end
               end
            end
            ST_SUM: begin
               if (accept) begin
                  if (sts.sum_match) begin
                     cmd.rd_clear = 1'b1;
                     state_in     = ST_READ;
                  end else begin
                     state_in = ST_SYNC1;
                  end
               end
            end
            ST_READ: begin
               state_in = ST_LOAD;
            end
            ST_LOAD: begin
               if (sts.out_free) begin
                  cmd.out_load = 1'b1;
                  if (sts.rd_last) begin
                     state_in = ST_SYNC1;
                  end else begin
                     cmd.rd_inc = 1'b1;
                     state_in   = ST_READ;
                  end
               end
            end
            default: begin
               state_in = ST_SYNC1;
            end
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC1;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sync_length_checksum_deframer.sv =====
// Deframer for packets of two sync bytes, message id, length, payload and an
// 8-bit additive checksum over all earlier bytes. While parsing, the block takes
// one byte beat per cycle. After a packet passes its checksum the block holds
// off input and sends the payload as a run of result beats; each beat is a
// registered read of the payload memory followed by a load of the result
// register. The input stays blocked until the last beat is loaded, also through
// any result-side stall; the last result may still wait while the next
// packet's bytes are taken.
// A timeout beat (tuser set) drops any packet in progress and gives no result.
module sync_length_checksum_deframer
   import slcd_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic              clock,
   input  logic              reset,
   // configuration writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [BYTE_W-1:0] csr_data,
   // received beats
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] rx_byte
   input  logic [0:0]        req_tuser,   // [0] timed_out
   // result beats
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // [7:0] message_id, [14:8] payload_length,
                                          // [20:15] byte_index, [28:21] payload_byte
   output logic              rsp_tlast    // last
);

   slcd_cmd_type cmd;
   slcd_sts_type sts;

   // parse and readout control
   slcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .timed_out  (req_tuser[0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   // checksum, header, payload memory and result register
   slcd_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rx_byte    (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // the result register is only loaded when it is empty or being drained
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten");

   // no input is taken while the payload is being read out
   a_no_input_in_readout: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_inc || cmd.out_load) |-> !req_tready)
      else $error("input taken during readout");

   // an empty packet gives a single last beat with a zero byte
   a_empty_packet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[14:8] == 7'd0)) |->
         (rsp_tlast && (rsp_tdata[28:21] == 8'd0) && (rsp_tdata[20:15] == 6'd0)))
      else $error("bad empty packet beat");

   // byte index stays inside the packet
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[14:8] != 7'd0)) |->
         ({1'b0, rsp_tdata[20:15]} < rsp_tdata[14:8]))
      else $error("byte index beyond packet length");

endmodule

// ===== dv/deframe_checker.sv =====
// channel monitor that predicts and compares the deframer's payload beats
module deframe_checker
   import slcd_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [BYTE_W-1:0] csr_data,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] rx_byte
   input  logic [0:0]        req_tuser,   // [0] timed_out
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,   // [7:0] message_id, [14:8] payload_length,
                                          // [20:15] byte_index, [28:21] payload_byte
   input  logic              rsp_tlast,   // last
   output int unsigned       mismatch_count,
   output int unsigned       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LEN_LSB   = BYTE_W;
   localparam int unsigned INDEX_LSB = BYTE_W + LEN_W;
   localparam int unsigned DATA_LSB  = BYTE_W + LEN_W + INDEX_W;
   localparam int unsigned PAD_LSB   = DATA_LSB + BYTE_W;

   // register values after reset
   localparam logic [BYTE_W-1:0] SYNC_FIRST_INIT   = 8'd170;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_INIT  = 8'd175;
   localparam logic [LEN_W-1:0]  LENGTH_LIMIT_INIT = 7'd30;

   typedef enum logic [2:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      TAKE_ID,
      TAKE_LEN,
      TAKE_DATA,
      TAKE_SUM
   } parse_phase_e;

   typedef struct packed {
      logic [BYTE_W-1:0]  message_id;
      logic [LEN_W-1:0]   payload_length;
      logic [INDEX_W-1:0] byte_index;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last;
   } payload_beat_t;

   // register copies
   logic [BYTE_W-1:0] sync_first_q;
   logic [BYTE_W-1:0] sync_second_q;
   logic [LEN_W-1:0]  length_limit_q;

   // parser copy
   parse_phase_e      phase;
   logic [7:0]        sum;
   logic [7:0]        id_held;
   logic [LEN_W-1:0]  len_held;
   logic [LEN_W-1:0]  fill;
   logic [7:0]        payload_mem [MAX_PAYLOAD];

   payload_beat_t     beats_due[$];

   function automatic int unsigned limit_now();
      return (length_limit_q > MAX_PAYLOAD) ? MAX_PAYLOAD : length_limit_q;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   task automatic queue_payload_beat(input int unsigned pos, input logic [7:0] value,
                                     input logic is_last);
      payload_beat_t b;
      b.message_id     = id_held;
      b.payload_length = len_held;
      b.byte_index     = pos[INDEX_W-1:0];
      b.payload_byte   = value;
      b.last           = is_last;
      beats_due.push_back(b);
   endtask

   // one received beat through the parser
   task automatic deframe_byte(input logic [7:0] c, input logic timed_out);
      int unsigned count;
      if (timed_out) begin
         phase = HUNT_FIRST;
         sum   = '0;
         return;
      end
      case (phase)
         HUNT_SECOND: begin
            // a miss goes back to hunting without retesting this byte
            phase = (c == sync_second_q) ? TAKE_ID : HUNT_FIRST;
            sum   = sum + c;
         end
         TAKE_ID: begin
            id_held = c;
            sum     = sum + c;
            phase   = TAKE_LEN;
         end
         TAKE_LEN: begin
            if (c <= limit_now()) begin
               len_held = c[LEN_W-1:0];
               fill     = '0;
               sum      = sum + c;
               phase    = (c != 8'd0) ? TAKE_DATA : TAKE_SUM;
            end else begin
               phase = HUNT_FIRST;
            end
         end
         TAKE_DATA: begin
            if (fill < MAX_PAYLOAD) begin
               payload_mem[fill] = c;
            end
            fill = fill + 1'b1;
            sum  = sum + c;
            if (fill >= len_held) begin
               phase = TAKE_SUM;
            end
         end
         TAKE_SUM: begin
            if (sum == c) begin
               count = (len_held > MAX_PAYLOAD) ? MAX_PAYLOAD : len_held;
               // empty packet still yields a single beat
               if (count == 0) begin
                  queue_payload_beat(0, 8'h00, 1'b1);
               end else begin
                  for (int unsigned i = 0; i < count; i++) begin
                     queue_payload_beat(i, payload_mem[i], (i + 1 == count));
                  end
               end
            end
            phase = HUNT_FIRST;
         end
         default: begin
            phase = (c == sync_first_q) ? HUNT_SECOND : HUNT_FIRST;
            sum   = c;
         end
      endcase
   endtask

   // compare an accepted result beat with the oldest one due
   task automatic check_result();
      payload_beat_t want;
      if (beats_due.size() == 0) begin
         report_mismatch("unexpected result beat", rsp_tdata, '0);
         return;
      end
      want = beats_due.pop_front();
      if (rsp_tdata[BYTE_W-1:0] !== want.message_id) begin
         report_mismatch("message_id", rsp_tdata[BYTE_W-1:0], want.message_id);
      end
      if (rsp_tdata[LEN_LSB +: LEN_W] !== want.payload_length) begin
         report_mismatch("payload_length", rsp_tdata[LEN_LSB +: LEN_W], want.payload_length);
      end
      if (rsp_tdata[INDEX_LSB +: INDEX_W] !== want.byte_index) begin
         report_mismatch("byte_index", rsp_tdata[INDEX_LSB +: INDEX_W], want.byte_index);
      end
      if (rsp_tdata[DATA_LSB +: BYTE_W] !== want.payload_byte) begin
         report_mismatch("payload_byte", rsp_tdata[DATA_LSB +: BYTE_W], want.payload_byte);
      end
      if (rsp_tdata[RSP_W-1:PAD_LSB] !== '0) begin
         report_mismatch("tdata padding", rsp_tdata[RSP_W-1:PAD_LSB], '0);
      end
      if (rsp_tlast !== want.last) begin
         report_mismatch("last", rsp_tlast, want.last);
      end
   endtask

   // watch all three channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         sync_first_q   = SYNC_FIRST_INIT;
         sync_second_q  = SYNC_SECOND_INIT;
         length_limit_q = LENGTH_LIMIT_INIT;
         phase          = HUNT_FIRST;
         sum            = '0;
         id_held        = '0;
         len_held       = '0;
         fill           = '0;
         mismatch_count = 0;
         beats_due.delete();
      end else begin
         // results leaving now were caused by earlier beats
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata, req_tuser[0]);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_FIRST:   sync_first_q   = csr_data;
               CSR_SYNC_SECOND:  sync_second_q  = csr_data;
               CSR_LENGTH_LIMIT: length_limit_q = csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count = beats_due.size();
   end

endmodule

// ===== dv/tb_sync_length_checksum_deframer.sv =====
// testbench top: drives packet streams and register writes, then gives the verdict
module tb_sync_length_checksum_deframer;
   timeunit 1ns;
   timeprecision 1ps;
   import slcd_pkg::*;

   localparam int unsigned MAX_PAYLOAD   = 32;
   localparam int unsigned PHASE_BEATS   = 40;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES   = 500;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam logic [1:0]  CSR_NONE      = 2'd3;   // index with no register behind it

   typedef enum int unsigned {
      FLAW_NONE,
      FLAW_SYNC2,
      FLAW_LONG,
      FLAW_SUM,
      FLAW_TIMEOUT
   } flaw_e;

   typedef struct packed {
      logic [7:0] value;
      logic       timed_out;
   } rx_beat_t;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index  = CSR_SYNC_FIRST;
   logic [BYTE_W-1:0] csr_data   = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;
   logic [0:0]        req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;
   int unsigned       mismatch_count;
   int unsigned       pending_count;

   // stimulus-side view of the registers, starting at reset values
   logic [7:0] sync_a  = 8'd170;
   logic [7:0] sync_b  = 8'd175;
   logic [6:0] len_cap = 7'd30;

   bit          tx_eager     = 1'b0;
   bit          rx_eager     = 1'b0;
   bit          hold_request = 1'b0;
   rx_beat_t    rx_stream[$];
   int unsigned cycle_count  = 0;

   sync_length_checksum_deframer #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   deframe_checker #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // reset, once at the start
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stall per beat, one long hold on request
   initial begin : rsp_side
      int unsigned wait_cycles;
      wait (reset == 1'b0);
      forever begin
         if (hold_request) begin
            wait_cycles  = HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (rx_eager) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 3);
         end
         if (wait_cycles > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (wait_cycles - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic int unsigned limit_now();
      return (len_cap > MAX_PAYLOAD) ? MAX_PAYLOAD : len_cap;
   endfunction

   function automatic void add_beat(input logic [7:0] value, input logic timed_out);
      rx_stream.push_back({value, timed_out});
   endfunction

   // one packet on the current sync values, optionally broken
   task automatic add_packet(input logic [7:0] id, input int unsigned len,
                             input flaw_e flaw, input int fill = -1);
      logic [7:0]  bytes_q[$];
      logic [7:0]  total;
      int unsigned cut;
      bytes_q.push_back(sync_a);
      bytes_q.push_back(sync_b);
      bytes_q.push_back(id);
      bytes_q.push_back(len[7:0]);
      repeat (len) bytes_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      total = '0;
      foreach (bytes_q[i]) total += bytes_q[i];
      bytes_q.push_back(total);
      case (flaw)
         FLAW_SYNC2: bytes_q[1] = sync_b ^ 8'($urandom_range(1, 255));
         FLAW_LONG:  bytes_q[3] = 8'($urandom_range(limit_now() + 1, 255));
         FLAW_SUM:   bytes_q[bytes_q.size() - 1] ^= 8'($urandom_range(1, 255));
         FLAW_TIMEOUT: begin
            cut = $urandom_range(1, bytes_q.size() - 1);
            while (bytes_q.size() > cut) void'(bytes_q.pop_back());
         end
         default: ;
      endcase
      foreach (bytes_q[i]) add_beat(bytes_q[i], 1'b0);
      if (flaw == FLAW_TIMEOUT) begin
         add_beat(8'($urandom), 1'b1);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // send the queued beats, then wait for every result and let the block settle
   task automatic play_stream();
      rx_beat_t    b;
      int unsigned gap;
      while (rx_stream.size() > 0) begin
         b   = rx_stream.pop_front();
         gap = tx_eager ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tdata  <= b.value;
         req_tuser  <= b.timed_out;
         do @(posedge clock); while (!req_tready);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  s1;
      logic [7:0]  s2;
      logic [6:0]  lim;
      int unsigned pick;
      int unsigned eff;
      int unsigned len;
      flaw_e       flaw;

      wait (reset == 1'b0);

      // directed cases on the reset register values
      add_packet(8'h00, 0, FLAW_NONE);          // empty packet
      add_packet(8'hFF, 1, FLAW_NONE, 255);
      add_packet(8'h01, 30, FLAW_NONE, 0);      // longest accepted length
      add_packet(8'h02, 31, FLAW_NONE);         // one over the limit
      add_beat(8'h00, 1'b1);
      add_packet(8'h03, 3, FLAW_SUM);
      add_packet(8'h04, 2, FLAW_SYNC2);
      add_beat(8'hFF, 1'b1);
      // failed second sync equal to the first sync value starts nothing
      add_beat(sync_a, 1'b0);
      add_packet(8'h05, 2, FLAW_NONE);
      add_beat(8'h00, 1'b1);
      // rejected length equal to the first sync value starts nothing
      add_beat(sync_a, 1'b0);
      add_beat(sync_b, 1'b0);
      add_beat(8'h06, 1'b0);
      add_beat(sync_a, 1'b0);
      add_beat(sync_b, 1'b0);
      add_beat(8'h07, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'(sync_a + sync_b + 8'h07), 1'b0);
      add_beat(8'h00, 1'b1);
      // timeout carrying the first sync value is not a byte
      add_beat(sync_a, 1'b1);
      add_beat(sync_b, 1'b0);
      add_beat(8'h09, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'(sync_a + sync_b + 8'h09), 1'b0);
      add_packet(8'h08, 4, FLAW_TIMEOUT);
      add_packet(8'h80, 5, FLAW_NONE);          // parse recovers after timeout
      play_stream();

      // random phases over several register settings
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               s1  = 8'h00;
               s2  = 8'hFF;
               lim = 7'd0;
            end
            1: begin
               s1  = 8'hFF;
               s2  = 8'h00;
               lim = 7'd64;
            end
            2: begin
               s1  = 8'($urandom);
               s2  = 8'($urandom);
               lim = 7'd32;
            end
            3: begin
               s1  = 8'($urandom);
               s2  = 8'($urandom);
               lim = 7'd31;
            end
            4: begin
               s1  = 8'h5A;
               s2  = 8'h5A;
               lim = 7'($urandom_range(0, 64));
            end
            default: begin
               s1  = 8'($urandom);
               s2  = 8'($urandom);
               lim = 7'($urandom_range(0, 64));
            end
         endcase
         write_csr(CSR_SYNC_FIRST, s1);
         write_csr(CSR_SYNC_SECOND, s2);
         write_csr(CSR_LENGTH_LIMIT, {1'b0, lim});
         if (p == 5) begin
            write_csr(CSR_NONE, 8'($urandom));
         end
         sync_a  = s1;
         sync_b  = s2;
         len_cap = lim;

         // phase 2 runs without idling, phase 3 backs up the result side
         tx_eager = (p == 2 || p == 3);
         rx_eager = (p == 2);
         if (p == 3) begin
            hold_request = 1'b1;
         end

         while (rx_stream.size() < PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               repeat ($urandom_range(1, 3)) add_beat(8'($urandom), 1'b0);
            end else if (pick < 12) begin
               add_beat(8'($urandom), 1'b1);
            end else begin
               eff  = limit_now();
               pick = $urandom_range(0, 99);
               if (pick < 50) begin
                  len = $urandom_range(0, (eff < 4) ? eff : 4);
               end else if (pick < 85) begin
                  len = $urandom_range(0, eff);
               end else begin
                  len = eff;
               end
               pick = $urandom_range(0, 99);
               flaw = (p == 3 || pick < 70) ? FLAW_NONE : flaw_e'($urandom_range(1, 4));
               add_packet(8'($urandom), len, flaw);
               // mostly clear the parse after a broken packet
               if (flaw != FLAW_NONE && $urandom_range(0, 3) != 0) begin
                  add_beat(8'($urandom), 1'b1);
               end
            end
         end
         // leave the parser hunting before the registers change
         add_beat(8'h00, 1'b1);
         play_stream();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/slcd_pkg.sv
src/slcd_datapath.sv
src/slcd_ctrl.sv
src/sync_length_checksum_deframer.sv
dv/deframe_checker.sv
dv/tb_sync_length_checksum_deframer.sv
